[rtl/core/rcfp_pkg.sv]
// Shared widths, constants and structs for the rounded-corner fade and RGBA8 pack block.
`timescale 1ns / 1ps

package rcfp_pkg;

    // Field widths of the ports.
    localparam int SIDE_W = 13;
    localparam int PIX_W  = 12;
    localparam int CH_W   = 16;
    localparam int OUT_W  = 8;

    // Fade fraction bits (Q1.16) and the matching divider/quotient width.
    localparam int FRAC_W = 16;

    // Configuration defaults.
    localparam int MAX_SIDE_DEF = 4096;
    localparam int SIDE_RESET   = 512;

    // Internal widths set by the 13-bit side and the 12-bit positions.
    localparam int DIST_W = PIX_W + 1;      // offset numerator |2p+1-n|
    localparam int EX_W   = 17;             // 10*d - 7n
    localparam int SQ_W   = 2 * EX_W;       // square of the corner excess
    localparam int SUM_W  = SQ_W + 1;       // sum of both squares
    localparam int WIDE_W = 20;             // products of d or n with edge constants
    localparam int NUM_W  = 17;             // edge numerator, below 10n
    localparam int NSQ_W  = 2 * SIDE_W;
    localparam int LIM_GW = 30;             // 9*n*n at the largest side

    // Scale factors of the corner and edge formulas.
    localparam int K3   = 3;
    localparam int K7   = 7;
    localparam int K9   = 9;
    localparam int K10  = 10;
    localparam int K75  = 75;
    localparam int K79  = 79;
    localparam int K92  = 92;
    localparam int K100 = 100;

    // Packing: channel * fade * 255, rounded at bit 28.
    localparam int PACK_SHIFT = 28;
    localparam int PROD_W     = CH_W + FRAC_W + 1;
    localparam int SCALED_W   = PROD_W + OUT_W;

    localparam logic [FRAC_W:0]  FADE_ONE     = 17'h1_0000;
    localparam logic [OUT_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [OUT_W-1:0] CH_MAX       = 8'hFF;

    // Values derived from the side length, stable while pixels flow.
    typedef struct packed {
        logic [SIDE_W-1:0]   n;
        logic [SIDE_W+1:0]   n3;
        logic [SIDE_W+2:0]   n7;
        logic [SIDE_W+3:0]   n10;
        logic [WIDE_W-1:0]   n79;
        logic [WIDE_W-1:0]   n92;
        logic [LIM_GW-1:0]   lim;
    } t_geo;

    // Pixel data that travels alongside the square root and divider.
    typedef struct packed {
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic             corner_on;
        logic             corner_zero;
        logic             edge_full;
        logic             edge_zero;
        logic [NUM_W-1:0] edge_num;
    } t_side;

endpackage

[rtl/core/rcfp_front.sv]
// Front pipeline: offsets, corner excess, squared distance and edge classification.
`timescale 1ns / 1ps

module rcfp_front #(
    parameter int LIM_W = 28
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [rcfp_pkg::PIX_W-1:0]  i_pixel_x,
    input  logic [rcfp_pkg::PIX_W-1:0]  i_pixel_y,
    input  logic [rcfp_pkg::CH_W-1:0]   i_red,
    input  logic [rcfp_pkg::CH_W-1:0]   i_green,
    input  logic [rcfp_pkg::CH_W-1:0]   i_blue,
    input  rcfp_pkg::t_geo              i_geo,
    output logic                        o_vld,
    output logic [LIM_W-1:0]            o_s,
    output rcfp_pkg::t_side             o_side
);
    import rcfp_pkg::*;

    // Distance of a pixel center from the canvas center, in units of 1/(2n).
    function automatic logic [DIST_W-1:0] f_offset(input logic [PIX_W-1:0] pos,
                                                  input logic [SIDE_W-1:0] n);
        logic [DIST_W-1:0] t;
        t = {pos, 1'b1};
        return (t >= DIST_W'(n)) ? t - DIST_W'(n) : DIST_W'(n) - t;
    endfunction

    logic [4:0]          r_vld;

    logic [PIX_W-1:0]    r0_x, r0_y;
    t_side               r0_side, n0_side;

    logic [DIST_W-1:0]   r1_dx, r1_dy, n1_dx, n1_dy;
    t_side               r1_side;

    logic [EX_W-1:0]     r2_ex, r2_ey, n2_ex, n2_ey;
    t_side               r2_side, n2_side;

    logic [SQ_W-1:0]     r3_sqx, r3_sqy;
    t_side               r3_side;

    logic [LIM_W-1:0]    r4_s, n4_s;
    t_side               r4_side, n4_side;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    // Stage 0: the channels enter the record that travels with the pixel.
    always_comb begin
        n0_side       = '0;
        n0_side.red   = i_red;
        n0_side.green = i_green;
        n0_side.blue  = i_blue;
    end

    // Stage 1: offset numerators.
    always_comb begin
        n1_dx = f_offset(r0_x, i_geo.n);
        n1_dy = f_offset(r0_y, i_geo.n);
    end

    // Stage 2: corner excess and edge class.
    always_comb begin
        logic [EX_W-1:0]   ax, ay;
        logic [DIST_W-1:0] dm;
        logic [WIDE_W-1:0] h100, h75;
        logic              on;
        ax = EX_W'(r1_dx) * EX_W'(K10);
        ay = EX_W'(r1_dy) * EX_W'(K10);
        on = (ax > EX_W'(i_geo.n7)) && (ay > EX_W'(i_geo.n7));
        n2_ex = on ? ax - EX_W'(i_geo.n7) : '0;
        n2_ey = on ? ay - EX_W'(i_geo.n7) : '0;
        dm    = (r1_dx > r1_dy) ? r1_dx : r1_dy;
        h100  = WIDE_W'(dm) * WIDE_W'(K100);
        h75   = WIDE_W'(dm) * WIDE_W'(K75);
        n2_side           = r1_side;
        n2_side.corner_on = on;
        n2_side.edge_full = (h100 <= i_geo.n92);
        n2_side.edge_zero = (h100 > i_geo.n92) && (h75 >= i_geo.n79);
        n2_side.edge_num  = (h100 > i_geo.n92) && (h75 < i_geo.n79) ?
                            NUM_W'(i_geo.n79 - h75) : '0;
    end

    // Stage 4: squared distance against the corner radius.
    always_comb begin
        logic [SUM_W-1:0] s;
        logic             zero;
        s    = SUM_W'(r3_sqx) + SUM_W'(r3_sqy);
        zero = r3_side.corner_on && (s >= SUM_W'(i_geo.lim));
        n4_side             = r3_side;
        n4_side.corner_zero = zero;
        n4_s = (r3_side.corner_on && !zero) ? LIM_W'(s) : '0;
    end

    // Payload registers of all stages.
    always_ff @(posedge i_clk) begin
        r0_x                <= i_pixel_x;
        r0_y                <= i_pixel_y;
        r0_side             <= n0_side;
        r1_dx               <= n1_dx;
        r1_dy               <= n1_dy;
        r1_side             <= r0_side;
        r2_ex               <= n2_ex;
        r2_ey               <= n2_ey;
        r2_side             <= n2_side;
        r3_sqx              <= SQ_W'(r2_ex) * SQ_W'(r2_ex);
        r3_sqy              <= SQ_W'(r2_ey) * SQ_W'(r2_ey);
        r3_side             <= r2_side;
        r4_s                <= n4_s;
        r4_side             <= n4_side;
    end

    assign o_vld  = r_vld[4];
    assign o_s    = r4_s;
    assign o_side = r4_side;

endmodule

[rtl/core/rcfp_sqrt.sv]
// Pipelined integer square root, one result bit per stage, with pixel data alongside.
`timescale 1ns / 1ps

module rcfp_sqrt #(
    parameter int R_W = 30
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  logic [2*R_W-1:0]    i_x,
    input  rcfp_pkg::t_side     i_side,
    output logic                o_vld,
    output logic [R_W-1:0]      o_root,
    output rcfp_pkg::t_side     o_side
);
    import rcfp_pkg::*;

    localparam int X_W   = 2 * R_W;
    localparam int REM_W = R_W + 3;

    logic [R_W-1:0]   r_vld;
    logic [REM_W-1:0] r_rem  [R_W];
    logic [R_W-1:0]   r_root [R_W];
    logic [X_W-1:0]   r_xs   [R_W];
    t_side            r_side [R_W];

    logic [REM_W-1:0] n_rem  [R_W];
    logic [R_W-1:0]   n_root [R_W];
    logic [X_W-1:0]   n_xs   [R_W];

    // One step per stage: bring down two radicand bits and try the next root bit.
    always_comb begin
        logic [REM_W-1:0] rem_in, cand, trial;
        logic [R_W-1:0]   root_in;
        logic [X_W-1:0]   xs_in;
        for (int k = 0; k < R_W; k++) begin
            if (k == 0) begin
                rem_in  = '0;
                root_in = '0;
                xs_in   = i_x;
            end else begin
                rem_in  = r_rem[k-1];
                root_in = r_root[k-1];
                xs_in   = r_xs[k-1];
            end
            cand  = {rem_in[REM_W-3:0], xs_in[X_W-1 -: 2]};
            trial = REM_W'({root_in, 2'b01});
            if (cand >= trial) begin
                n_rem[k]  = cand - trial;
                n_root[k] = {root_in[R_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = cand;
                n_root[k] = {root_in[R_W-2:0], 1'b0};
            end
            n_xs[k] = {xs_in[X_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[R_W-2:0], i_vld};
        end
    end

    // Stage registers, pixel data shifted along with them.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < R_W; k++) begin
            r_rem[k]  <= n_rem[k];
            r_root[k] <= n_root[k];
            r_xs[k]   <= n_xs[k];
            r_side[k] <= (k == 0) ? i_side : r_side[(k == 0) ? 0 : k-1];
        end
    end

    assign o_vld  = r_vld[R_W-1];
    assign o_root = r_root[R_W-1];
    assign o_side = r_side[R_W-1];

endmodule

[rtl/core/rcfp_div.sv]
// Two-lane pipelined restoring divider, one quotient bit per stage, for corner and edge.
`timescale 1ns / 1ps

module rcfp_div #(
    parameter int DV_W = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_vld,
    input  logic [1:0][DV_W-1:0]                  i_rem0,
    input  logic [1:0][rcfp_pkg::FRAC_W-1:0]      i_low,
    input  logic [1:0][DV_W-1:0]                  i_divisor,
    input  rcfp_pkg::t_side                       i_side,
    output logic                                  o_vld,
    output logic [1:0][rcfp_pkg::FRAC_W-1:0]      o_quot,
    output rcfp_pkg::t_side                       o_side
);
    import rcfp_pkg::*;

    // The low word shifts dividend bits out at the top and quotient bits in below.
    logic [FRAC_W-1:0]          r_vld;
    logic [1:0][DV_W-1:0]       r_rem  [FRAC_W];
    logic [1:0][FRAC_W-1:0]     r_low  [FRAC_W];
    t_side                      r_side [FRAC_W];

    logic [1:0][DV_W-1:0]       n_rem  [FRAC_W];
    logic [1:0][FRAC_W-1:0]     n_low  [FRAC_W];

    // One compare and subtract per lane and stage.
    always_comb begin
        logic [DV_W-1:0]   rem_in;
        logic [FRAC_W-1:0] low_in;
        logic [DV_W:0]     t;
        for (int k = 0; k < FRAC_W; k++) begin
            for (int l = 0; l < 2; l++) begin
                rem_in = (k == 0) ? i_rem0[l] : r_rem[(k == 0) ? 0 : k-1][l];
                low_in = (k == 0) ? i_low[l]  : r_low[(k == 0) ? 0 : k-1][l];
                t      = {rem_in, low_in[FRAC_W-1]};
                if (t >= {1'b0, i_divisor[l]}) begin
                    n_rem[k][l] = DV_W'(t - {1'b0, i_divisor[l]});
                    n_low[k][l] = {low_in[FRAC_W-2:0], 1'b1};
                end else begin
                    n_rem[k][l] = DV_W'(t);
                    n_low[k][l] = {low_in[FRAC_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[FRAC_W-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < FRAC_W; k++) begin
            r_rem[k]  <= n_rem[k];
            r_low[k]  <= n_low[k];
            r_side[k] <= (k == 0) ? i_side : r_side[(k == 0) ? 0 : k-1];
        end
    end

    assign o_vld  = r_vld[FRAC_W-1];
    assign o_quot = r_low[FRAC_W-1];
    assign o_side = r_side[FRAC_W-1];

endmodule

[rtl/core/rcfp_pack.sv]
// Back pipeline: combines corner and edge fades, scales each channel and packs to 8 bits.
`timescale 1ns / 1ps

module rcfp_pack (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [rcfp_pkg::FRAC_W-1:0]   i_corner_dist,
    input  logic [rcfp_pkg::FRAC_W-1:0]   i_edge_quot,
    input  rcfp_pkg::t_side               i_side,
    output logic                          o_vld,
    output logic [rcfp_pkg::OUT_W-1:0]    o_red,
    output logic [rcfp_pkg::OUT_W-1:0]    o_green,
    output logic [rcfp_pkg::OUT_W-1:0]    o_blue
);
    import rcfp_pkg::*;

    localparam int FP_W = 2 * (FRAC_W + 1);

    logic [2:0]                  r_vld;
    logic [FP_W-1:0]             r1_prod, n1_prod;
    logic [2:0][CH_W-1:0]        r1_col;
    logic [2:0][PROD_W-1:0]      r2_p, n2_p;
    logic [2:0][OUT_W-1:0]       r3_ch, n3_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    // Stage 1: corner and edge fades in Q1.16, multiplied.
    always_comb begin
        logic [FRAC_W:0] corner, edge_f;
        if (!i_side.corner_on) begin
            corner = FADE_ONE;
        end else if (i_side.corner_zero) begin
            corner = '0;
        end else begin
            corner = FADE_ONE - {1'b0, i_corner_dist};
        end
        if (i_side.edge_full) begin
            edge_f = FADE_ONE;
        end else if (i_side.edge_zero) begin
            edge_f = '0;
        end else begin
            edge_f = {1'b0, i_edge_quot};
        end
        n1_prod = FP_W'(corner) * FP_W'(edge_f);
    end

    // Stage 2: round the fade back to Q1.16 and apply it to each channel.
    always_comb begin
        logic [FP_W:0]   rnd;
        logic [FRAC_W:0] fade;
        rnd  = (FP_W+1)'(r1_prod) + (FP_W+1)'(FADE_ONE >> 1);
        fade = (FRAC_W+1)'(rnd >> FRAC_W);
        for (int c = 0; c < 3; c++) begin
            n2_p[c] = PROD_W'(r1_col[c]) * PROD_W'(fade);
        end
    end

    // Stage 3: times 255, round half up at bit 28, saturate.
    always_comb begin
        logic [SCALED_W-1:0] w;
        logic [SCALED_W-1:0] v;
        for (int c = 0; c < 3; c++) begin
            w = SCALED_W'({r2_p[c], {OUT_W{1'b0}}}) - SCALED_W'(r2_p[c])
                + (SCALED_W'(1) << (PACK_SHIFT - 1));
            v = w >> PACK_SHIFT;
            n3_ch[c] = (v > SCALED_W'(CH_MAX)) ? CH_MAX : OUT_W'(v);
        end
    end

    always_ff @(posedge i_clk) begin
        r1_prod   <= n1_prod;
        r1_col    <= {i_side.blue, i_side.green, i_side.red};
        r2_p      <= n2_p;
        r3_ch     <= n3_ch;
    end

    assign o_vld   = r_vld[2];
    assign o_red   = r3_ch[0];
    assign o_green = r3_ch[1];
    assign o_blue  = r3_ch[2];

endmodule

[rtl/core/rounded_corner_fade_pack.sv]
// Top level of the rounded-corner fade and RGBA8 pack block.
//
// Usage: a pixel (column, row, and three Q4.12 intensities) is taken at each rising
// edge where start is high and busy is low. busy never rises, so one pixel per
// clock is accepted. Each pixel produces exactly one RGBA8 result, shown for one
// cycle with o_result_valid high; results leave in the order pixels came in.
// The receiver cannot hold results off, and the block never needs it to.
// A pixel passes through the front pipeline, the square-root pipeline (one bit
// per stage, R_W stages, where R_W = (LIM_W + 33) / 2 and LIM_W is the width of
// 9*n*n at the largest side), the 16-stage divider and the pack pipeline. The
// side length is written through its own valid/ready channel; ready is always
// high. Write it only while no pixel is in flight; a pixel may follow in the next
// cycle. A synchronous active-low reset empties the pipeline and sets the side
// length to 512.
`timescale 1ns / 1ps

module rounded_corner_fade_pack #(
    parameter int MAX_SIDE = rcfp_pkg::MAX_SIDE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [rcfp_pkg::PIX_W-1:0]   i_pixel_x,
    input  logic [rcfp_pkg::PIX_W-1:0]   i_pixel_y,
    input  logic [rcfp_pkg::CH_W-1:0]    i_red_in,
    input  logic [rcfp_pkg::CH_W-1:0]    i_green_in,
    input  logic [rcfp_pkg::CH_W-1:0]    i_blue_in,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [rcfp_pkg::SIDE_W-1:0]  i_side_length,
    output logic                         o_result_valid,
    output logic [rcfp_pkg::OUT_W-1:0]   o_red_out,
    output logic [rcfp_pkg::OUT_W-1:0]   o_green_out,
    output logic [rcfp_pkg::OUT_W-1:0]   o_blue_out,
    output logic [rcfp_pkg::OUT_W-1:0]   o_alpha_out
);
    import rcfp_pkg::*;

    localparam int SIDE_TOP = (1 << SIDE_W) - 1;
    localparam int NMAX     = (MAX_SIDE < SIDE_TOP) ? MAX_SIDE : SIDE_TOP;
    localparam int LIM_W    = $clog2(K9 * NMAX * NMAX + 1);
    localparam int R_W      = (LIM_W + 2 * FRAC_W + 1) / 2;
    localparam int X_W      = 2 * R_W;
    localparam int DV_W     = $clog2(K10 * NMAX + 1);

    logic [SIDE_W-1:0] r_side;
    logic [SIDE_W-1:0] r_n, n_n;
    logic [NSQ_W-1:0]  r_nsq;
    t_geo              r_geo, n_geo;

    logic              acc;
    logic              fr_vld;
    logic [LIM_W-1:0]  fr_s;
    t_side             fr_side;
    logic              sq_vld;
    logic [R_W-1:0]    sq_root;
    t_side             sq_side;
    logic              dv_vld;
    logic [1:0][DV_W-1:0]   dv_rem0, dv_divisor;
    logic [1:0][FRAC_W-1:0] dv_low, dv_quot;
    t_side             dv_side;

    // Handshakes: the pipeline never stalls.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign acc         = start && !busy;

    // Side length register, written by a configuration transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SIDE_W'(SIDE_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_side <= i_side_length;
        end
    end

    // Effective side: zero counts as one, large values clamp to the maximum.
    always_comb begin
        if (r_side == '0) begin
            n_n = SIDE_W'(1);
        end else if (r_side > SIDE_W'(NMAX)) begin
            n_n = SIDE_W'(NMAX);
        end else begin
            n_n = r_side;
        end
    end

    // Side-derived constants, each ready before the first pipeline stage that uses it.
    always_comb begin
        n_geo.n   = n_n;
        n_geo.n3  = (SIDE_W+2)'(r_n) * (SIDE_W+2)'(K3);
        n_geo.n7  = (SIDE_W+3)'(r_n) * (SIDE_W+3)'(K7);
        n_geo.n10 = (SIDE_W+4)'(r_n) * (SIDE_W+4)'(K10);
        n_geo.n79 = WIDE_W'(r_n) * WIDE_W'(K79);
        n_geo.n92 = WIDE_W'(r_n) * WIDE_W'(K92);
        n_geo.lim = LIM_GW'(r_nsq) * LIM_GW'(K9);
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_nsq <= NSQ_W'(r_n) * NSQ_W'(r_n);
        r_geo <= n_geo;
    end

    rcfp_front #(
        .LIM_W (LIM_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (acc),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .i_red     (i_red_in),
        .i_green   (i_green_in),
        .i_blue    (i_blue_in),
        .i_geo     (r_geo),
        .o_vld     (fr_vld),
        .o_s       (fr_s),
        .o_side    (fr_side)
    );

    // The corner distance is sqrt(S * 2^32) / (3n); the root comes first.
    rcfp_sqrt #(
        .R_W (R_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (fr_vld),
        .i_x     (X_W'({fr_s, {(2*FRAC_W){1'b0}}})),
        .i_side  (fr_side),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Lane 0 divides the root by 3n, lane 1 the edge numerator times 2^16 by 10n.
    assign dv_rem0[0]    = DV_W'(sq_root >> FRAC_W);
    assign dv_low[0]     = sq_root[FRAC_W-1:0];
    assign dv_divisor[0] = DV_W'(r_geo.n3);
    assign dv_rem0[1]    = DV_W'(sq_side.edge_num);
    assign dv_low[1]     = '0;
    assign dv_divisor[1] = DV_W'(r_geo.n10);

    rcfp_div #(
        .DV_W (DV_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (sq_vld),
        .i_rem0    (dv_rem0),
        .i_low     (dv_low),
        .i_divisor (dv_divisor),
        .i_side    (sq_side),
        .o_vld     (dv_vld),
        .o_quot    (dv_quot),
        .o_side    (dv_side)
    );

    rcfp_pack u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (dv_vld),
        .i_corner_dist (dv_quot[0]),
        .i_edge_quot   (dv_quot[1]),
        .i_side        (dv_side),
        .o_vld         (o_result_valid),
        .o_red         (o_red_out),
        .o_green       (o_green_out),
        .o_blue        (o_blue_out)
    );

    assign o_alpha_out = ALPHA_OPAQUE;

endmodule

[verif/tb_rounded_corner_fade_pack.sv]
// Self-checking testbench for the rounded-corner fade and RGBA8 pack block.
`timescale 1ns / 1ps

module tb_rounded_corner_fade_pack;

    import rcfp_pkg::*;

    // One packed RGBA8 pixel as the block presents it.
    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
        logic [OUT_W-1:0] alpha;
    } t_rgba;

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                start         = 1'b0;
    logic                busy;
    logic [PIX_W-1:0]    i_pixel_x     = '0;
    logic [PIX_W-1:0]    i_pixel_y     = '0;
    logic [CH_W-1:0]     i_red_in      = '0;
    logic [CH_W-1:0]     i_green_in    = '0;
    logic [CH_W-1:0]     i_blue_in     = '0;
    logic                i_cfg_valid   = 1'b0;
    logic                o_cfg_ready;
    logic [SIDE_W-1:0]   i_side_length = '0;
    logic                o_result_valid;
    logic [OUT_W-1:0]    o_red_out;
    logic [OUT_W-1:0]    o_green_out;
    logic [OUT_W-1:0]    o_blue_out;
    logic [OUT_W-1:0]    o_alpha_out;

    // Side length as last written, and the pixels still owed by the block.
    logic [SIDE_W-1:0]   canvas_side = SIDE_W'(SIDE_RESET);
    t_rgba               pending_rgba[$];
    int                  mismatch_count = 0;

    // Sender burst shaping.
    bit                  gaps_on    = 1'b1;
    int                  burst_left = 0;

    rounded_corner_fade_pack dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_red_in       (i_red_in),
        .i_green_in     (i_green_in),
        .i_blue_in      (i_blue_in),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_side_length  (i_side_length),
        .o_result_valid (o_result_valid),
        .o_red_out      (o_red_out),
        .o_green_out    (o_green_out),
        .o_blue_out     (o_blue_out),
        .o_alpha_out    (o_alpha_out)
    );

    // Free-running clock with a 2 ns period.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog for a hung pipeline.
    initial begin
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // The canvas side the block actually uses: zero acts as one, large sides saturate.
    function automatic longint unsigned active_side(input logic [SIDE_W-1:0] raw);
        longint unsigned n;
        n = raw;
        if (n == 0) n = 1;
        if (n > MAX_SIDE_DEF) n = MAX_SIDE_DEF;
        return n;
    endfunction

    // Integer square root, one result bit at a time from the top.
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            probe = root | (64'd1 << b);
            if (probe * probe <= v) root = probe;
        end
        return root;
    endfunction

    // Distance numerator of a pixel centre from the canvas centre.
    function automatic longint unsigned centre_offset(input longint unsigned pos,
                                                      input longint unsigned n);
        longint unsigned t;
        t = 2 * pos + 1;
        return (t >= n) ? t - n : n - t;
    endfunction

    // Channel times fade times 255, rounded half up at bit 28 and saturated.
    function automatic logic [OUT_W-1:0] scale_channel(input longint unsigned c,
                                                       input longint unsigned fade);
        longint unsigned v;
        v = (c * fade * 255 + (64'd1 << 27)) >> 28;
        return (v > 255) ? CH_MAX : v[OUT_W-1:0];
    endfunction

    // Expected RGBA8 output for one pixel under the current side length.
    function automatic t_rgba fade_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                                         input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                         input logic [CH_W-1:0] b);
        longint unsigned n, dx, dy, dm, ex, ey, sq_sum, lim, root_q, corner, edge_fade, fade;
        t_rgba px;
        n  = active_side(canvas_side);
        dx = centre_offset(x, n);
        dy = centre_offset(y, n);

        // Rounded corner: only where both offsets pass 0.7.
        corner = 65536;
        if (10 * dx > 7 * n && 10 * dy > 7 * n) begin
            ex     = 10 * dx - 7 * n;
            ey     = 10 * dy - 7 * n;
            sq_sum = ex * ex + ey * ey;
            lim    = 9 * n * n;
            if (sq_sum >= lim) begin
                corner = 0;
            end else begin
                root_q = floor_sqrt((sq_sum << 32) / lim);
                corner = (root_q >= 65536) ? 0 : 65536 - root_q;
            end
        end

        // Edge ramp over the outer 0.08 of the larger offset.
        dm = (dx > dy) ? dx : dy;
        if (100 * dm <= 92 * n) begin
            edge_fade = 65536;
        end else if (75 * dm >= 79 * n) begin
            edge_fade = 0;
        end else begin
            edge_fade = ((79 * n - 75 * dm) * 65536) / (10 * n);
            if (edge_fade > 65536) edge_fade = 65536;
        end

        fade     = (corner * edge_fade + 32768) >> 16;
        px.red   = scale_channel(r, fade);
        px.green = scale_channel(g, fade);
        px.blue  = scale_channel(b, fade);
        px.alpha = ALPHA_OPAQUE;
        return px;
    endfunction

    // Drive one pixel, honoring the burst pattern, and record its expected result.
    task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                              input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b);
        if (gaps_on && burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0) burst_left--;
        start      <= 1'b1;
        i_pixel_x  <= x;
        i_pixel_y  <= y;
        i_red_in   <= r;
        i_green_in <= g;
        i_blue_in  <= b;
        do @(posedge i_clk); while (busy);
        pending_rgba.insert(pending_rgba.size(), fade_pixel(x, y, r, g, b));
    endtask

    // Drain the pipeline, then write the side length through its channel.
    task automatic write_side(input logic [SIDE_W-1:0] side);
        start <= 1'b0;
        while (pending_rgba.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid   <= 1'b1;
        i_side_length <= side;
        do @(posedge i_clk); while (!o_cfg_ready);
        canvas_side = side;
        i_cfg_valid <= 1'b0;
    endtask

    // A coordinate biased toward a region of the canvas of side n.
    //   0: outer corner band, 1: edge ramp band, 2: anywhere on the canvas,
    //   3: the whole 12-bit range, partly off the canvas when the side is below 4096.
    function automatic logic [PIX_W-1:0] pick_coord(input longint unsigned n, input int region);
        longint unsigned band, v;
        case (region)
            0:       band = n * 15 / 100 + 1;
            1:       band = n * 5 / 100 + 1;
            default: band = n;
        endcase
        if (region == 3) return PIX_W'($urandom_range(0, 4095));
        v = $urandom_range(0, band - 1);
        if ($urandom_range(0, 1)) v = n - 1 - v;
        return v[PIX_W-1:0];
    endfunction

    // Intensities mostly near the unity range, with saturation and the extremes mixed in.
    function automatic logic [CH_W-1:0] pick_intensity();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4, 5: return CH_W'($urandom_range(0, 16'h1000));
            6, 7:    return CH_W'($urandom_range(0, 16'h1100));
            default: return CH_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // Compare one output field and log any difference.
    task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Every result transfer is matched against the oldest expected pixel.
    always @(posedge i_clk) begin
        t_rgba want;
        if (i_rst_n && o_result_valid) begin
            if (pending_rgba.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %0d %0d %0d %0d", $time,
                         o_red_out, o_green_out, o_blue_out, o_alpha_out);
                mismatch_count++;
            end else begin
                want = pending_rgba.pop_front();
                check_field("red", want.red, o_red_out);
                check_field("green", want.green, o_green_out);
                check_field("blue", want.blue, o_blue_out);
                check_field("alpha", want.alpha, o_alpha_out);
            end
        end
    end

    // Reset side of 512: centre, corners, edge midpoints and intensity extremes.
    task automatic test_default_side();
        send_pixel(12'd255, 12'd255, 16'h1000, 16'h0800, 16'h0000);
        send_pixel(12'd0,   12'd0,   16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(12'd511, 12'd511, 16'h1000, 16'h1000, 16'h1000);
        send_pixel(12'd0,   12'd511, 16'hFFFF, 16'h0001, 16'h0FFF);
        send_pixel(12'd470, 12'd470, 16'h1000, 16'hFFFF, 16'h0800);
        send_pixel(12'd0,   12'd255, 16'h1000, 16'h0C00, 16'h0400);
        send_pixel(12'd497, 12'd260, 16'hFFFF, 16'h1000, 16'h0000);
        send_pixel(12'd255, 12'd505, 16'h0808, 16'h1000, 16'hFFFF);
    endtask

    // Positions at or past the canvas side.
    task automatic test_outside_canvas();
        send_pixel(12'd4095, 12'd4095, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(12'd600,  12'd100,  16'h1000, 16'h1000, 16'h1000);
        send_pixel(12'd512,  12'd256,  16'h1000, 16'hFFFF, 16'h0000);
    endtask

    // Zero, tiny, oversized and boundary side lengths.
    task automatic test_side_extremes();
        logic [SIDE_W-1:0] sides[7];
        longint unsigned   n;
        sides = '{13'd0, 13'd1, 13'd15, 13'd4097, 13'd8191, 13'd16, 13'd4096};
        foreach (sides[i]) begin
            write_side(sides[i]);
            n = active_side(sides[i]);
            send_pixel(12'd0, 12'd0, 16'h1000, 16'hFFFF, 16'h0800);
            send_pixel(PIX_W'(n / 2), PIX_W'(n - 1), 16'hFFFF, 16'h1000, 16'h0000);
        end
    endtask

    // Random pixels over several side lengths, mostly in the corner and edge bands.
    task automatic test_random_pixels();
        logic [SIDE_W-1:0] sides[7];
        longint unsigned   n;
        int                pick;
        logic [PIX_W-1:0]  x, y;
        sides = '{13'd512, 13'd4096, 13'd16, 13'($urandom_range(17, 4095)), 13'd8191,
                  13'd23, 13'($urandom_range(100, 1000))};
        foreach (sides[i]) begin
            write_side(sides[i]);
            n = active_side(sides[i]);
            gaps_on = (i % 3 != 1);
            repeat (65) begin
                pick = $urandom_range(0, 19);
                if (pick < 10) begin
                    x = pick_coord(n, 0);
                    y = pick_coord(n, 0);
                end else if (pick < 14) begin
                    x = pick_coord(n, 1);
                    y = pick_coord(n, 2);
                end else if (pick < 16) begin
                    x = pick_coord(n, 2);
                    y = pick_coord(n, 1);
                end else if (pick < 19) begin
                    x = pick_coord(n, 2);
                    y = pick_coord(n, 2);
                end else begin
                    x = pick_coord(n, 3);
                    y = pick_coord(n, 3);
                end
                send_pixel(x, y, pick_intensity(), pick_intensity(), pick_intensity());
            end
        end
        gaps_on = 1'b1;
    endtask

    // Test sequence.
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_side();
        test_outside_canvas();
        test_side_extremes();
        test_random_pixels();

        // Let the pipeline drain, then watch for stray results.
        start <= 1'b0;
        while (pending_rgba.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/rcfp_pkg.sv
rtl/core/rcfp_front.sv
rtl/core/rcfp_sqrt.sv
rtl/core/rcfp_div.sv
rtl/core/rcfp_pack.sv
rtl/core/rounded_corner_fade_pack.sv
verif/tb_rounded_corner_fade_pack.sv
